// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assert failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: src/rsmp_pkg.sv
// ---------------------------------------------------------------------------
// rsmp_pkg
// Types and fixed widths of the polyline resampler.
// ---------------------------------------------------------------------------
package rsmp_pkg;
  localparam int CW = 32;   // coordinate width
  localparam int SW = 31;   // spacing width
  localparam int PW = 64;   // product width of the shared multiplier
  localparam int NAX = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-1:0]        mag_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_S, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SEARCH,
    ST_DIV_START, ST_DIV_WAIT, ST_EMIT_START, ST_EMIT_INT, ST_EMIT_END
  } state_t;
endpackage

// File: src/polyline_resampler_unit.sv
// ---------------------------------------------------------------------------
// polyline_resampler_unit
// Resamples a polyline of Q16.16 points to a bounded XY spacing.
// ---------------------------------------------------------------------------
// Sequence: a closing point squares the spacing and both XY deltas, searches
//   n from 1 up to MAX_SEGMENTS, divides the three axis deltas by the count
//   when the segment splits, and emits a word per cycle when the slot is free.
// Points are taken one at a time; the serial divider sets most of the cost.
// Reset clears the stored point and the sequencer; spacing returns to 1.0.
`include "assert_macros.svh"

module polyline_resampler_unit import rsmp_pkg::*; #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [SW-1:0] cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  coord_t        in_x,
  input  coord_t        in_y,
  input  coord_t        in_z,
  input  logic          path_end,
  output logic          out_valid,
  input  logic          out_ready,
  output coord_t        out_x,
  output coord_t        out_y,
  output coord_t        out_z,
  output logic          run_last,
  output logic          path_done,
  output logic          capped
);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int TW = 2 * SW + 2 * NW + 1;  // holds n^2 * s^2 and its step
  localparam logic [NW-1:0] NMAX = NW'(MAX_SEGMENTS);

  state_t state, state_next;

  logic [SW-1:0]  spacing;
  logic           have_prev;
  coord_t         prev [NAX];
  coord_t         cur  [NAX];
  logic           cur_end;
  mag_t           mag  [NAX];
  logic           neg  [NAX];
  logic [PW-1:0]  s2;
  logic [PW:0]    d2;
  logic [TW-1:0]  tsq, inc;
  logic [NW-1:0]  n, cnt, j;
  logic           cap;
  logic [1:0]     ax;
  mag_t           qm [NAX];
  logic [NW-1:0]  rm [NAX];
  mag_t           qa [NAX];
  logic [NW-1:0]  ra [NAX];

  mag_t           mul_a;
  logic [PW-1:0]  mul_p;
  logic           div_start, div_done;
  mag_t           div_quo;
  logic [NW-1:0]  div_rem;
  logic [SW-1:0]  s_eff;
  logic           slot_free, ge, accept, out_load;
  coord_t         in_pt [NAX];

  assign in_pt[0]  = in_x;
  assign in_pt[1]  = in_y;
  assign in_pt[2]  = in_z;
  assign s_eff     = (spacing == '0) ? SW'(1) : spacing;
  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign ge        = tsq >= TW'(d2);
  // a new word enters the output register this cycle
  assign out_load  = (accept && !have_prev && path_end) ||
                     (slot_free && (state == ST_EMIT_START || state == ST_EMIT_INT ||
                                    state == ST_EMIT_END));

  rsmp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_a), .p(mul_p));

  rsmp_div #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mag[ax]), .divisor(cnt),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept && have_prev) state_next = ST_SQ_S;
      ST_SQ_S:      state_next = ST_SQ_X;
      ST_SQ_X:      state_next = ST_SQ_Y;
      ST_SQ_Y:      state_next = ST_SQ_SUM;
      ST_SQ_SUM:    state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (ge && n == NW'(1)) state_next = ST_EMIT_START;
        else if (ge || n == NMAX) state_next = ST_DIV_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = (ax == 2'd2) ? ST_EMIT_START : ST_DIV_START;
      end
      ST_EMIT_START: begin
        if (slot_free) begin
          if (cnt != NW'(1)) state_next = ST_EMIT_INT;
          else state_next = cur_end ? ST_EMIT_END : ST_IDLE;
        end
      end
      ST_EMIT_INT: begin
        if (slot_free && j == cnt - 1'b1) state_next = cur_end ? ST_EMIT_END : ST_IDLE;
      end
      ST_EMIT_END:  if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = mag[1];
    case (state)
      ST_IDLE:      in_ready = !out_valid;
      ST_SQ_S:      mul_a = mag_t'(s_eff);
      ST_SQ_X:      mul_a = mag[0];
      ST_DIV_START: div_start = 1'b1;
      default:      mul_a = mag[1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      spacing   <= SW'(65536);
      have_prev <= 1'b0;
      out_valid <= 1'b0;
      for (int a = 0; a < NAX; a++) prev[a] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) spacing <= cfg_wdata;
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!have_prev) begin
              if (path_end) begin
                // lone point: pass it straight through
                out_valid <= 1'b1;
                out_x     <= in_x;
                out_y     <= in_y;
                out_z     <= in_z;
                run_last  <= 1'b1;
                path_done <= 1'b1;
                capped    <= 1'b0;
              end else begin
                have_prev <= 1'b1;
                for (int a = 0; a < NAX; a++) prev[a] <= in_pt[a];
              end
            end
            cur_end <= path_end;
            for (int a = 0; a < NAX; a++) begin
              cur[a] <= in_pt[a];
              neg[a] <= in_pt[a] < prev[a];
              mag[a] <= (in_pt[a] < prev[a]) ? mag_t'(prev[a] - in_pt[a])
                                              : mag_t'(in_pt[a] - prev[a]);
            end
          end
        end
        ST_SQ_X:   s2 <= mul_p;
        ST_SQ_Y:   d2 <= {1'b0, mul_p};
        ST_SQ_SUM: begin
          d2  <= d2 + {1'b0, mul_p};
          tsq <= TW'(s2);
          inc <= TW'(s2) + (TW'(s2) << 1);
          n   <= NW'(1);
        end
        ST_SEARCH: begin
          // walk n upward: (n+1)^2 s^2 = n^2 s^2 + (2n+1) s^2
          if (ge) begin
            cnt <= n;
            cap <= 1'b0;
            ax  <= 2'd0;
          end else if (n == NMAX) begin
            cnt <= NMAX;
            cap <= 1'b1;
            ax  <= 2'd0;
          end else begin
            n   <= n + 1'b1;
            tsq <= tsq + inc;
            inc <= inc + (TW'(s2) << 1);
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            qm[ax] <= div_quo;
            rm[ax] <= div_rem;
            ax     <= ax + 1'b1;
          end
        end
        ST_EMIT_START: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_x     <= prev[0];
            out_y     <= prev[1];
            out_z     <= prev[2];
            run_last  <= (cnt == NW'(1)) && !cur_end;
            path_done <= 1'b0;
            capped    <= cap;
            j         <= NW'(1);
            for (int a = 0; a < NAX; a++) begin
              qa[a] <= qm[a];
              ra[a] <= rm[a];
            end
            if (cnt == NW'(1) && !cur_end)
              for (int a = 0; a < NAX; a++) prev[a] <= cur[a];
          end
        end
        ST_EMIT_INT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_x     <= neg[0] ? prev[0] - coord_t'(qa[0]) : prev[0] + coord_t'(qa[0]);
            out_y     <= neg[1] ? prev[1] - coord_t'(qa[1]) : prev[1] + coord_t'(qa[1]);
            out_z     <= neg[2] ? prev[2] - coord_t'(qa[2]) : prev[2] + coord_t'(qa[2]);
            run_last  <= (j == cnt - 1'b1) && !cur_end;
            path_done <= 1'b0;
            capped    <= cap;
            j         <= j + 1'b1;
            // advance j*m/count by the stored quotient and remainder
            for (int a = 0; a < NAX; a++) begin
              if ({1'b0, ra[a]} + {1'b0, rm[a]} >= {1'b0, cnt}) begin
                ra[a] <= NW'({1'b0, ra[a]} + {1'b0, rm[a]} - {1'b0, cnt});
                qa[a] <= qa[a] + qm[a] + 1'b1;
              end else begin
                ra[a] <= ra[a] + rm[a];
                qa[a] <= qa[a] + qm[a];
              end
            end
            if (j == cnt - 1'b1 && !cur_end)
              for (int a = 0; a < NAX; a++) prev[a] <= cur[a];
          end
        end
        ST_EMIT_END: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_x     <= cur[0];
            out_y     <= cur[1];
            out_z     <= cur[2];
            run_last  <= 1'b1;
            path_done <= 1'b1;
            capped    <= cap;
            have_prev <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_RST(a_done_is_last, out_valid && path_done |-> run_last)
  `ASSERT_RST(a_busy_not_ready, state != ST_IDLE |-> !in_ready)
  `ASSERT_RST(a_search_range, state == ST_SEARCH |-> n != '0 && n <= NMAX)
endmodule

// File: src/rsmp_mul.sv
// ---------------------------------------------------------------------------
// rsmp_mul
// Shared unsigned multiplier, product registered.
// ---------------------------------------------------------------------------
module rsmp_mul import rsmp_pkg::*; (
  input  logic          clk,
  input  mag_t          a,
  input  mag_t          b,
  output logic [PW-1:0] p
);
  always_ff @(posedge clk) begin
    p <= PW'(a) * PW'(b);
  end
endmodule

// File: src/rsmp_div.sv
// ---------------------------------------------------------------------------
// rsmp_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsmp_div import rsmp_pkg::*; #(
  parameter int NW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mag_t          dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output mag_t          quo,
  output logic [NW-1:0] rem
);
  localparam int BW = $clog2(CW + 1);
  logic [BW-1:0] cnt;
  logic          busy;
  logic [NW:0]   racc;
  logic [NW-1:0] dvs;
  logic [NW:0]   trial;

  assign trial = {racc[NW-1:0], quo[CW-1]};
  assign rem   = racc[NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BW'(CW);
        quo  <= dividend;
        racc <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // subtract when the partial remainder allows, shift in the quotient bit
        if (trial >= {1'b0, dvs}) begin
          racc <= trial - {1'b0, dvs};
          quo  <= {quo[CW-2:0], 1'b1};
        end else begin
          racc <= trial;
          quo  <= {quo[CW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == BW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sim/tb_polyline_resampler_unit.sv
// ---------------------------------------------------------------------------
// tb_polyline_resampler_unit
// Self-checking bench for the polyline resampler. A table of directed points
// comes first. Random polylines follow, under several spacings and idle
// patterns. Every emitted word is compared against an in-bench predictor.
// ---------------------------------------------------------------------------
module tb_polyline_resampler_unit import rsmp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SEG = 32;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 400;               // worst closing point plus margin

  typedef struct packed {
    coord_t x, y, z;
    logic   last, done, cap;
  } point_t;

  typedef struct {
    coord_t x, y, z;
    logic   fin;
    logic   typed;       // expected word typed in below
    point_t want;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_x = '0, in_y = '0, in_z = '0;
  logic path_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_x, out_y, out_z;
  logic run_last, path_done, capped;

  // predictor state
  logic [SW-1:0] spacing;
  coord_t last_x, last_y, last_z;
  logic   holding;
  point_t emitted_q[$];

  int mismatches = 0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;

  polyline_resampler_unit #(.MAX_SEGMENTS(MAX_SEG)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .path_end(path_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .run_last(run_last), .path_done(path_done), .capped(capped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_resampler_unit regression: fail");
      $finish;
    end
  end

  // One interpolated coordinate: start + j*(end-start)/n, truncated toward zero.
  function automatic coord_t blend(coord_t a, coord_t b, int j, int n);
    longint d;
    longint unsigned q;
    d = longint'(b) - longint'(a);
    q = (longint'(j) * (d < 0 ? -d : d)) / n;
    return (d < 0) ? coord_t'(longint'(a) - longint'(q)) : coord_t'(longint'(a) + longint'(q));
  endfunction

  // Work out every word one accepted point causes and queue them.
  task automatic resample_point(coord_t x, coord_t y, coord_t z, logic fin);
    longint dx, dy;
    logic [127:0] len2, step, sq;
    int n_seg;
    logic cap;
    point_t p;
    if (!holding) begin
      if (fin) begin
        p = '{x, y, z, 1'b1, 1'b1, 1'b0};
        emitted_q.push_back(p);
      end else begin
        last_x = x; last_y = y; last_z = z; holding = 1'b1;
      end
      return;
    end
    dx = longint'(x) - longint'(last_x);
    dy = longint'(y) - longint'(last_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    // Smallest count whose span covers the length; zero spacing acts as one.
    n_seg = 0;
    for (int n = 1; n <= MAX_SEG; n++) begin
      step = 128'(n) * 128'(spacing == 0 ? 1 : spacing);
      sq = step * step;
      if (n_seg == 0 && sq >= len2) n_seg = n;
    end
    cap = (n_seg == 0);
    if (cap) n_seg = MAX_SEG;
    p = '{last_x, last_y, last_z, (n_seg == 1) && !fin, 1'b0, cap};
    emitted_q.push_back(p);
    for (int j = 1; j < n_seg; j++) begin
      p = '{blend(last_x, x, j, n_seg), blend(last_y, y, j, n_seg),
            blend(last_z, z, j, n_seg), (j == n_seg - 1) && !fin, 1'b0, cap};
      emitted_q.push_back(p);
    end
    if (fin) begin
      p = '{x, y, z, 1'b1, 1'b1, cap};
      emitted_q.push_back(p);
      holding = 1'b0;
    end else begin
      last_x = x; last_y = y; last_z = z;
    end
  endtask

  // Offer one point; hold valid and payload until the word is taken.
  task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin, logic typed,
                            point_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z; path_end <= fin;
    do @(posedge clk); while (!in_ready);
    if (typed) emitted_q.push_back(want);
    else resample_point(x, y, z, fin);
  endtask

  // Drain, let a pending first point settle, then write the spacing.
  task automatic set_spacing(logic [SW-1:0] v);
    in_valid <= 1'b0;
    while (emitted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    spacing = v;
  endtask

  // Receiver: randomly stall, and check each word taken against the oldest expectation.
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (emitted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word x=%h y=%h z=%h", out_x, out_y, out_z);
      end else begin
        want = emitted_q.pop_front();
        if (want !== {out_x, out_y, out_z, run_last, path_done, capped}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h z=%h l=%b d=%b c=%b got x=%h y=%h z=%h l=%b d=%b c=%b",
                     want.x, want.y, want.z, want.last, want.done, want.cap,
                     out_x, out_y, out_z, run_last, path_done, capped);
        end
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  // Clamp a 64-bit sum back into the coordinate range.
  function automatic coord_t clamp(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return coord_t'(v);
  endfunction

  // Random polylines: steps sized against the spacing, with some wild points.
  task automatic random_paths(int n_items);
    int sent, len, k;
    longint lim;
    coord_t px, py, pz;
    sent = 0;
    px = $urandom; py = $urandom; pz = $urandom;
    while (sent < n_items) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          px = $urandom; py = $urandom; pz = $urandom;
        end else begin
          k = $urandom_range(0, 36);
          lim = longint'(spacing == 0 ? 1 : spacing) * k;
          px = clamp(longint'(px) + longint'({$urandom, $urandom} % (2 * lim + 1)) - lim);
          py = clamp(longint'(py) + longint'({$urandom, $urandom} % (2 * lim + 1)) - lim);
          pz = $urandom;
        end
        send_point(px, py, pz, i == len - 1, 1'b0, '0);
        sent++;
      end
    end
  endtask

  vec_t dir_tbl[$];
  int idle_tbl[5] = '{0, 51, 0, 30, 0};
  int stall_tbl[5] = '{0, 0, 51, 30, 0};
  logic [SW-1:0] space_tbl[5];

  initial begin
    spacing = 31'd65536;
    holding = 1'b0;
    last_x = '0; last_y = '0; last_z = '0;
    // Lone points right after reset, at zero and both extremes: they pass straight through.
    dir_tbl = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 1'b0}},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1,
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1, 1'b0}},
      '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1,
        '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1, 1'b0}},
      // First point stores, then length exactly one spacing, then just over it.
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, '0},
      '{32'sd65536, 32'sd0, 32'sd7, 1'b0, 1'b0, '0},
      '{32'sd65536, 32'sd65537, 32'sd0, 1'b0, 1'b0, '0},
      '{32'sd65536, 32'sd65537, 32'sd100, 1'b0, 1'b0, '0},      // zero length
      '{-32'sd196608, 32'sd327680, -32'sd9, 1'b0, 1'b0, '0},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0, '0}, // capped
      '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0, '0}, // capped end
      '{32'sd100, 32'sd200, 32'sd300, 1'b0, 1'b0, '0},
      '{32'sd131177, 32'sd200, 32'h7fffffff, 1'b1, 1'b0, '0},
      '{32'sd5, 32'sd5, 32'sd5, 1'b0, 1'b0, '0},
      '{32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b0, '0},                  // zero-length end
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, '0},
      '{32'sd1310720, -32'sd1376256, 32'sd1000, 1'b0, 1'b0, '0},
      '{32'sd1310723, -32'sd1376250, -32'sd1000, 1'b1, 1'b0, '0}
    };
    space_tbl = '{31'd1, 31'd0, 31'h7fffffff, 31'($urandom_range(1, 31'h7fffffff)), 31'd196608};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset spacing of 1.0.
    foreach (dir_tbl[i])
      send_point(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].fin,
                 dir_tbl[i].typed, dir_tbl[i].want);

    // Random phases: each with its own spacing and idle pattern.
    for (int ph = 0; ph < 5; ph++) begin
      set_spacing(space_tbl[ph]);
      send_idle = idle_tbl[ph];
      recv_stall = stall_tbl[ph];
      random_paths(80);
    end

    in_valid <= 1'b0;
    while (emitted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && emitted_q.size() == 0)
      $display("polyline_resampler_unit regression: pass");
    else
      $display("polyline_resampler_unit regression: fail");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/rsmp_pkg.sv
src/rsmp_mul.sv
src/rsmp_div.sv
src/polyline_resampler_unit.sv
sim/tb_polyline_resampler_unit.sv
